### src/per_channel_duty_limiter_defines.svh
// Assertion macros shared by the duty limiter checker.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef PER_CHANNEL_DUTY_LIMITER_DEFINES_SVH
`define PER_CHANNEL_DUTY_LIMITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCDL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("duty limiter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCDL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("duty limiter check failed");

`endif

### src/pcdl_pkg.sv
// Package for the per-channel duty limiter: sizes, register map, codes and states.
// Used by the top level and the port checker; no dependencies.
`timescale 1ns / 1ps
package pcdl_pkg;

  localparam int CHANNELS = 16;
  localparam int HISTORY  = 64;

  localparam int START_W = 22;
  localparam int END_W   = 23;
  localparam int DUR_W   = 16;
  localparam int CHAN_W  = 4;
  localparam int BUDGET_W = 17;
  localparam int DROP_W  = 24;
  localparam int CAUSE_W = 2;

  localparam int CH_IDX_W   = $clog2(CHANNELS);
  localparam int SLOT_W     = $clog2(HISTORY);
  localparam int CNT_W      = $clog2(HISTORY + 1);
  localparam int USED_W     = DUR_W + $clog2(HISTORY + 1);
  localparam int HIST_DEPTH = CHANNELS * HISTORY;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int HIST_DW    = START_W + END_W;

  localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_MAX_PULSE = 2'd0;
  localparam logic [1:0] REG_MIN_GAP   = 2'd1;
  localparam logic [1:0] REG_WINDOW    = 2'd2;
  localparam logic [1:0] REG_BUDGET    = 2'd3;

  localparam logic [DUR_W-1:0]    MAX_PULSE_RST = 16'd2000;
  localparam logic [DUR_W-1:0]    MIN_GAP_RST   = 16'd60;
  localparam logic [DUR_W-1:0]    WINDOW_RST    = 16'd10000;
  localparam logic [BUDGET_W-1:0] BUDGET_RST    = 17'd4800;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_GAP     = 2'd1,
    CAUSE_BUDGET  = 2'd2,
    CAUSE_CHANNEL = 2'd3
  } cause_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DECIDE,
    ST_DONE
  } state_e;

endpackage

### src/per_channel_duty_limiter.sv
// Per-channel duty limiter: channel and gap check, a walk over the channel's history ring
// and a budget decision. A gap or channel rejection goes from CHECK to DONE; other items
// pass WALK (skipped for an empty ring) and DECIDE, then DONE registers the result.
// The walk reads one history RAM entry per cycle; a new item is taken only in IDLE.
// Reset restores register defaults and clears channel state and the drop count; the
// history RAM is not cleared, as only entries below each channel's fill count are read.
`timescale 1ns / 1ps
module per_channel_duty_limiter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pcdl_pkg::START_W-1:0]   start_ms_i,
  input  logic [pcdl_pkg::DUR_W-1:0]     duration_ms_i,
  input  logic [pcdl_pkg::CHAN_W-1:0]    channel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           accepted_o,
  output logic [pcdl_pkg::DUR_W-1:0]     granted_ms_o,
  output logic [pcdl_pkg::CAUSE_W-1:0]   reject_cause_o,
  output logic [pcdl_pkg::DROP_W-1:0]    dropped_total_o,
  output logic                           history_exhausted_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcdl_pkg::PADDR_W-1:0]   paddr,
  input  logic [pcdl_pkg::PDATA_W-1:0]   pwdata,
  output logic [pcdl_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  import pcdl_pkg::*;

  logic [DUR_W-1:0]    max_pulse_q, min_gap_q, window_q;
  logic [BUDGET_W-1:0] budget_q;

  state_e state_q, state_d;

  logic [START_W-1:0] start_q, start_d;
  logic [DUR_W-1:0]   dur_q, dur_d;
  logic [CHAN_W-1:0]  chan_q, chan_d;
  logic [END_W-1:0]   end_q, end_d;
  logic [END_W-1:0]   wstart_q, wstart_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  cause_e             cause_q, cause_d;
  logic               exhausted_q, exhausted_d;

  logic [END_W-1:0]    last_end_q [CHANNELS];
  logic [END_W-1:0]    last_end_d [CHANNELS];
  logic [CHANNELS-1:0] chan_used_q, chan_used_d;
  logic [SLOT_W-1:0]   head_q [CHANNELS];
  logic [SLOT_W-1:0]   head_d [CHANNELS];
  logic [CNT_W-1:0]    count_q [CHANNELS];
  logic [CNT_W-1:0]    count_d [CHANNELS];
  logic [DROP_W-1:0]   drop_q, drop_d;

  logic               out_valid_q, out_valid_d;
  logic               out_acc_q, out_acc_d;
  logic [DUR_W-1:0]   out_granted_q, out_granted_d;
  cause_e             out_cause_q, out_cause_d;
  logic [DROP_W-1:0]  out_drop_q, out_drop_d;
  logic               out_exh_q, out_exh_d;

  logic [CH_IDX_W-1:0] ch_idx;
  logic                chan_ok;
  logic [END_W:0]      gap_lim;
  logic                gap_fail;
  logic [END_W-1:0]    end_sum;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    k_next;
  logic [SLOT_W-1:0]   head_cur;
  logic [SLOT_W-1:0]   rd_slot;
  logic [END_W-1:0]    e_end, e_start, e_beg;
  logic                hit_old, more;
  logic                out_free;
  logic                commit;
  logic [HIST_DW-1:0]  rdata;
  logic [HIST_AW-1:0]  raddr, waddr;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pulse_q <= MAX_PULSE_RST;
      min_gap_q   <= MIN_GAP_RST;
      window_q    <= WINDOW_RST;
      budget_q    <= BUDGET_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[PADDR_W-1:2])
        REG_MAX_PULSE: max_pulse_q <= pwdata[DUR_W-1:0];
        REG_MIN_GAP:   min_gap_q   <= pwdata[DUR_W-1:0];
        REG_WINDOW:    window_q    <= pwdata[DUR_W-1:0];
        REG_BUDGET:    budget_q    <= pwdata[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_MAX_PULSE: prdata = PDATA_W'(max_pulse_q);
      REG_MIN_GAP:   prdata = PDATA_W'(min_gap_q);
      REG_WINDOW:    prdata = PDATA_W'(window_q);
      REG_BUDGET:    prdata = PDATA_W'(budget_q);
      default:       prdata = '0;
    endcase
  end

  // Shared decode for the item in flight.
  assign ch_idx   = CH_IDX_W'(chan_q);
  assign chan_ok  = 32'(chan_q) < CHANNELS;
  assign gap_lim  = (END_W + 1)'(last_end_q[ch_idx]) + (END_W + 1)'(min_gap_q);
  assign gap_fail = chan_used_q[ch_idx] && ((END_W + 1)'(start_q) < gap_lim);
  assign end_sum  = END_W'(start_q) + END_W'(dur_q);
  assign cnt      = count_q[ch_idx];
  assign head_cur = head_q[ch_idx];
  assign k_next   = k_q + CNT_W'(1);
  assign e_end    = rdata[END_W-1:0];
  assign e_start  = END_W'(rdata[HIST_DW-1:END_W]);
  assign e_beg    = (e_start > wstart_q) ? e_start : wstart_q;
  assign hit_old  = e_end <= wstart_q;
  assign more     = k_next < cnt;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (state_q)
      ST_CHECK: rd_slot = (head_cur == '0) ? SLOT_W'(HISTORY - 1) : head_cur - SLOT_W'(1);
      ST_WALK:  rd_slot = (slot_q == '0) ? SLOT_W'(HISTORY - 1) : slot_q - SLOT_W'(1);
      default:  rd_slot = slot_q;
    endcase
  end

  assign raddr = HIST_AW'(ch_idx) * HIST_AW'(HISTORY) + HIST_AW'(rd_slot);
  assign waddr = HIST_AW'(ch_idx) * HIST_AW'(HISTORY) + HIST_AW'(head_cur);

  pcdl_ram #(
    .WIDTH(HIST_DW),
    .DEPTH(HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (waddr),
    .wdata_i ({start_q, end_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!chan_ok || gap_fail) begin
          state_d = ST_DONE;
        end else if (cnt == '0) begin
          state_d = ST_DECIDE;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (hit_old || !more) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    start_d       = start_q;
    dur_d         = dur_q;
    chan_d        = chan_q;
    end_d         = end_q;
    wstart_d      = wstart_q;
    used_d        = used_q;
    k_d           = k_q;
    slot_d        = rd_slot;
    cause_d       = cause_q;
    exhausted_d   = exhausted_q;
    last_end_d    = last_end_q;
    chan_used_d   = chan_used_q;
    head_d        = head_q;
    count_d       = count_q;
    drop_d        = drop_q;
    commit        = 1'b0;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_acc_d     = out_acc_q;
    out_granted_d = out_granted_q;
    out_cause_d   = out_cause_q;
    out_drop_d    = out_drop_q;
    out_exh_d     = out_exh_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          start_d = start_ms_i;
          dur_d   = (duration_ms_i > max_pulse_q) ? max_pulse_q : duration_ms_i;
          chan_d  = channel_i;
        end
      end
      ST_CHECK: begin
        end_d       = end_sum;
        wstart_d    = (end_sum > END_W'(window_q)) ? end_sum - END_W'(window_q) : '0;
        used_d      = USED_W'(dur_q);
        k_d         = '0;
        exhausted_d = 1'b0;
        if (!chan_ok) begin
          cause_d = CAUSE_CHANNEL;
        end else if (gap_fail) begin
          cause_d = CAUSE_GAP;
        end else begin
          cause_d = CAUSE_NONE;
        end
      end
      ST_WALK: begin
        if (!hit_old) begin
          used_d = used_q + USED_W'(e_end - e_beg);
          k_d    = k_next;
          if (!more) begin
            exhausted_d = cnt == CNT_W'(HISTORY);
          end
        end
      end
      ST_DECIDE: begin
        if (used_q > USED_W'(budget_q)) begin
          cause_d = CAUSE_BUDGET;
        end else begin
          cause_d             = CAUSE_NONE;
          commit              = 1'b1;
          last_end_d[ch_idx]  = end_q;
          chan_used_d[ch_idx] = 1'b1;
          head_d[ch_idx]      = (head_cur == SLOT_W'(HISTORY - 1)) ? '0
                                                                   : head_cur + SLOT_W'(1);
          if (cnt != CNT_W'(HISTORY)) begin
            count_d[ch_idx] = cnt + CNT_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          if (cause_q != CAUSE_NONE && drop_q != DROP_MAX) begin
            drop_d = drop_q + DROP_W'(1);
          end
          out_valid_d   = 1'b1;
          out_acc_d     = cause_q == CAUSE_NONE;
          out_granted_d = dur_q;
          out_cause_d   = cause_q;
          out_drop_d    = drop_d;
          out_exh_d     = exhausted_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chan_used_q <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_end_q[i] <= '0;
        head_q[i]     <= '0;
        count_q[i]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      chan_used_q <= chan_used_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      last_end_q  <= last_end_d;
      head_q      <= head_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q       <= start_d;
    dur_q         <= dur_d;
    chan_q        <= chan_d;
    end_q         <= end_d;
    wstart_q      <= wstart_d;
    used_q        <= used_d;
    k_q           <= k_d;
    slot_q        <= slot_d;
    cause_q       <= cause_d;
    exhausted_q   <= exhausted_d;
    out_acc_q     <= out_acc_d;
    out_granted_q <= out_granted_d;
    out_cause_q   <= out_cause_d;
    out_drop_q    <= out_drop_d;
    out_exh_q     <= out_exh_d;
  end

  assign in_ready_o          = state_q == ST_IDLE;
  assign out_valid_o         = out_valid_q;
  assign accepted_o          = out_acc_q;
  assign granted_ms_o        = out_granted_q;
  assign reject_cause_o      = out_cause_q;
  assign dropped_total_o     = out_drop_q;
  assign history_exhausted_o = out_exh_q;

endmodule

### src/pcdl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module pcdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/pcdl_checker.sv
// Port-level checker for the per-channel duty limiter, bound to the top level.
// Depends on pcdl_pkg and the assertion macros in per_channel_duty_limiter_defines.svh.
`timescale 1ns / 1ps
`include "per_channel_duty_limiter_defines.svh"
module pcdl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         accepted_o,
  input logic [pcdl_pkg::CAUSE_W-1:0] reject_cause_o,
  input logic [pcdl_pkg::DROP_W-1:0]  dropped_total_o,
  input logic                         history_exhausted_o
);

  import pcdl_pkg::*;

  // Only one item is in work at a time, so a transfer closes the input side.
  `PCDL_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)

  // A gap rejection skips the history walk and never keeps the pulse.
  `PCDL_ASSERT_SAME(a_gap_no_walk, out_valid_o && (reject_cause_o == CAUSE_GAP),
                    !history_exhausted_o && !accepted_o)

  // The drop count seen by consecutive results never decreases.
  `PCDL_ASSERT_SAME(a_drop_monotonic, (out_valid_o && out_ready_i) ##1 out_valid_o,
                    dropped_total_o >= $past(dropped_total_o))

  // A stalled result stays offered.
  `PCDL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

endmodule

bind per_channel_duty_limiter pcdl_checker u_pcdl_checker (.*);
